/* hw/rtl/ptp_pkg.sv */
// ----------------------------------------------------------------------------
// Polynomial term parser package
// Shared widths, character codes and transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

  localparam int COEF_WIDTH = 63;
  localparam int DEG_WIDTH  = 32;

  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } ptp_in_t;

  typedef struct packed {
    logic [COEF_WIDTH-1:0] coefficient;
    logic [DEG_WIDTH-1:0]  degree;
    logic                  final_term;
  } ptp_out_t;

endpackage

`default_nettype wire

/* hw/rtl/polynomial_text_term_parser.sv */
// ----------------------------------------------------------------------------
// Polynomial term parser
// Parses a*x^n terms from a character stream and emits one term per separator.
// ----------------------------------------------------------------------------
// Path: a result is written to the output register after its closing character is
// accepted (input register, then result register); a stalled output can hold it back.
// Throughput: one character per cycle unless a result is held back by out_stall.
// Reset: synchronous, active low; clears the valid bits of both registers and the parse state.
`default_nettype none

module polynomial_text_term_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ptp_pkg::ptp_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ptp_pkg::ptp_out_t     out_data
);

  localparam int CW = ptp_pkg::COEF_WIDTH;
  localparam int DW = ptp_pkg::DEG_WIDTH;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_COEF   = 3'd1;
  localparam logic [2:0] PH_XSLOT  = 3'd2;
  localparam logic [2:0] PH_AFTERX = 3'd3;
  localparam logic [2:0] PH_DEGD   = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;

  logic             s1_valid_r;
  ptp_pkg::ptp_in_t s1_data_r;
  logic [2:0]       phase_r, phase_nxt;
  logic [CW-1:0]    coef_r, coef_nxt;
  logic [DW-1:0]    deg_r, deg_nxt;
  logic             open_r, open_nxt;
  logic             out_valid_r;
  ptp_pkg::ptp_out_t out_data_r;

  logic             close;
  logic             emit;
  logic             is_digit;
  logic [3:0]       digit;
  logic [CW+3:0]    coef_wide;
  logic [DW+3:0]    deg_wide;
  logic [CW-1:0]    coef_push;
  logic [DW-1:0]    deg_push;
  logic [7:0]       ch;
  logic             out_free;
  logic             s1_adv;

  assign ch       = s1_data_r.character;
  assign is_digit = (ch >= ptp_pkg::CH_ZERO) && (ch <= ptp_pkg::CH_NINE);
  assign digit    = ch[3:0];

  // Multiply by ten as two shifts and an add; any carry out saturates.
  assign coef_wide = ({4'b0, coef_r} << 3) + ({4'b0, coef_r} << 1) + {{CW{1'b0}}, digit};
  assign deg_wide  = ({4'b0, deg_r} << 3) + ({4'b0, deg_r} << 1) + {{DW{1'b0}}, digit};
  assign coef_push = (coef_wide[CW+3:CW] != 4'd0) ? {CW{1'b1}} : coef_wide[CW-1:0];
  assign deg_push  = (deg_wide[DW+3:DW] != 4'd0) ? {DW{1'b1}} : deg_wide[DW-1:0];

  always_comb begin
    phase_nxt = phase_r;
    coef_nxt  = coef_r;
    deg_nxt   = deg_r;
    open_nxt  = open_r;
    close     = 1'b0;
    unique case (phase_r)
      PH_COEF: begin
        if (is_digit) begin
          coef_nxt = coef_push;
        end else if (ch == ptp_pkg::CH_STAR) begin
          deg_nxt   = {{(DW-1){1'b0}}, 1'b1};
          phase_nxt = PH_XSLOT;
        end else if (ch == ptp_pkg::CH_SPACE) begin
          phase_nxt = PH_TRAIL;
        end else begin
          close = 1'b1;
        end
      end
      PH_XSLOT: begin
        phase_nxt = PH_AFTERX;
      end
      PH_AFTERX: begin
        if (ch == ptp_pkg::CH_CARET) begin
          deg_nxt   = '0;
          phase_nxt = PH_DEGD;
        end else if (ch == ptp_pkg::CH_SPACE) begin
          phase_nxt = PH_TRAIL;
        end else begin
          close = 1'b1;
        end
      end
      PH_DEGD: begin
        if (is_digit) begin
          deg_nxt = deg_push;
        end else if (ch == ptp_pkg::CH_SPACE) begin
          phase_nxt = PH_TRAIL;
        end else begin
          close = 1'b1;
        end
      end
      PH_TRAIL: begin
        close = (ch != ptp_pkg::CH_SPACE);
      end
      default: begin
        if (ch != ptp_pkg::CH_SPACE) begin
          open_nxt = 1'b1;
          if (is_digit) begin
            coef_nxt  = {{(CW-4){1'b0}}, digit};
            deg_nxt   = '0;
            phase_nxt = PH_COEF;
          end else if (ch == ptp_pkg::CH_X) begin
            coef_nxt  = {{(CW-1){1'b0}}, 1'b1};
            deg_nxt   = {{(DW-1){1'b0}}, 1'b1};
            phase_nxt = PH_AFTERX;
          end else if (ch == ptp_pkg::CH_STAR) begin
            coef_nxt  = '0;
            deg_nxt   = {{(DW-1){1'b0}}, 1'b1};
            phase_nxt = PH_XSLOT;
          end else begin
            coef_nxt = '0;
            deg_nxt  = '0;
            close    = 1'b1;
          end
        end
      end
    endcase
  end

  assign emit     = close || (s1_data_r.line_end && open_nxt);
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (out_free || !emit);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      coef_r  <= '0;
      deg_r   <= '0;
      open_r  <= 1'b0;
    end else if (s1_adv) begin
      if (emit || s1_data_r.line_end) begin
        phase_r <= PH_LEAD;
        coef_r  <= '0;
        deg_r   <= '0;
        open_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        coef_r  <= coef_nxt;
        deg_r   <= deg_nxt;
        open_r  <= open_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_data_r.coefficient <= coef_nxt;
      out_data_r.degree      <= deg_nxt;
      out_data_r.final_term  <= s1_data_r.line_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/ptp_checker.sv */
// ----------------------------------------------------------------------------
// Polynomial term parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire ptp_pkg::ptp_out_t out_data
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input side only stalls when a result is held back downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A new result follows an accepted input transaction through the input and result registers.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input transaction");

  // Reset leaves both channels idle.
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("channels busy after reset");

endmodule

bind polynomial_text_term_parser ptp_checker u_ptp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
